>>> rtl/jsu_pkg.sv
package jsu_pkg;

  // Parse phase of the unescaper.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  // Result kind codes.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam int unsigned MaxResults = 3;

  // Character constants.
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChLowN      = 8'h6E;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowU      = 8'h75;
  localparam logic [7:0] ChSpace     = 8'h20;

  // UTF-8 lead and continuation marks.
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Cont  = 8'h80;

  // Input beat.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       input_end;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       last_of_run;
  } out_t;

  // Results caused by one input beat, in order from index 0.
  typedef struct packed {
    out_t [MaxResults-1:0] res;
    logic [1:0]            count;
  } run_t;

endpackage

>>> rtl/json_string_unescaper_core.sv
// Results of a beat go through the run register, then the output register, to dst.
// Throughput: one input beat per cycle while each beat gives at most one result
// and dst is not stalled; a beat that decodes to a multi-byte UTF-8 run stalls
// the input until the last result of that run is moving to the output register.
// The single output register sets the rate: one result a cycle unless dst stalls.
// Reset (rst, synchronous): waits for an opening quote, clears hex state and buffers.
module json_string_unescaper_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_stall,
  input  jsu_pkg::in_t  src_data,
  output logic          dst_valid,
  input  logic          dst_stall,
  output jsu_pkg::out_t dst_data
);

  jsu_pkg::phase_t phase;
  jsu_pkg::phase_t phase_next;
  logic [1:0]      hex_digits_seen;
  logic [1:0]      hex_digits_seen_next;
  logic [15:0]     code_point;
  logic [15:0]     code_point_next;
  jsu_pkg::run_t   run;
  logic            can_load;
  logic            accept;

  assign src_stall = !can_load;
  assign accept    = src_valid && can_load;

  // Escape decode for the incoming beat.
  jsu_decode u_decode (
    .beat                 (src_data),
    .phase                (phase),
    .hex_digits_seen      (hex_digits_seen),
    .code_point           (code_point),
    .phase_next           (phase_next),
    .hex_digits_seen_next (hex_digits_seen_next),
    .code_point_next      (code_point_next),
    .run                  (run)
  );

  // Parser state advances on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= jsu_pkg::PH_IDLE;
      hex_digits_seen <= 2'd0;
      code_point      <= 16'd0;
    end else if (accept) begin
      phase           <= phase_next;
      hex_digits_seen <= hex_digits_seen_next;
      code_point      <= code_point_next;
    end
  end

  // Result run and output register.
  jsu_run_buf u_run_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .run_in    (run),
    .can_load  (can_load),
    .out_valid (dst_valid),
    .out_stall (dst_stall),
    .out_data  (dst_data)
  );

endmodule

>>> rtl/jsu_decode.sv
module jsu_decode (
  input  jsu_pkg::in_t    beat,
  input  jsu_pkg::phase_t phase,
  input  logic [1:0]      hex_digits_seen,
  input  logic [15:0]     code_point,
  output jsu_pkg::phase_t phase_next,
  output logic [1:0]      hex_digits_seen_next,
  output logic [15:0]     code_point_next,
  output jsu_pkg::run_t   run
);

  logic [7:0]  c;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp;
  logic        is_space;
  logic        esc_ok;
  logic [7:0]  esc_byte;

  assign c = beat.in_byte;

  // Hex digit value of the current byte.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      hex_val = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp       = {code_point[11:0], hex_val};
  assign is_space = c inside {jsu_pkg::ChSpace, [8'h09:8'h0D]};

  // Single-letter escape table.
  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = c;
    case (c)
      jsu_pkg::ChQuote, jsu_pkg::ChBackslash, jsu_pkg::ChSlash: esc_byte = c;
      jsu_pkg::ChLowB: esc_byte = 8'h08;
      jsu_pkg::ChLowF: esc_byte = 8'h0C;
      jsu_pkg::ChLowN: esc_byte = 8'h0A;
      jsu_pkg::ChLowR: esc_byte = 8'h0D;
      jsu_pkg::ChLowT: esc_byte = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  // Next phase and gathered code point.
  always_comb begin
    phase_next           = phase;
    hex_digits_seen_next = hex_digits_seen;
    code_point_next      = code_point;
    if (beat.input_end) begin
      phase_next           = jsu_pkg::PH_IDLE;
      hex_digits_seen_next = 2'd0;
      code_point_next      = 16'd0;
    end else begin
      case (phase)
        jsu_pkg::PH_IDLE: begin
          if (c == jsu_pkg::ChQuote) begin
            phase_next = jsu_pkg::PH_STR;
          end
        end
        jsu_pkg::PH_STR: begin
          if (c == jsu_pkg::ChQuote || c < jsu_pkg::ChSpace) begin
            phase_next           = jsu_pkg::PH_IDLE;
            hex_digits_seen_next = 2'd0;
            code_point_next      = 16'd0;
          end else if (c == jsu_pkg::ChBackslash) begin
            phase_next = jsu_pkg::PH_ESC;
          end
        end
        jsu_pkg::PH_ESC: begin
          hex_digits_seen_next = 2'd0;
          code_point_next      = 16'd0;
          if (c == jsu_pkg::ChLowU) begin
            phase_next = jsu_pkg::PH_HEX;
          end else if (esc_ok) begin
            phase_next = jsu_pkg::PH_STR;
          end else begin
            phase_next = jsu_pkg::PH_IDLE;
          end
        end
        default: begin
          if (!hex_ok) begin
            phase_next           = jsu_pkg::PH_IDLE;
            hex_digits_seen_next = 2'd0;
            code_point_next      = 16'd0;
          end else if (hex_digits_seen == 2'd3) begin
            phase_next           = jsu_pkg::PH_STR;
            hex_digits_seen_next = 2'd0;
            code_point_next      = 16'd0;
          end else begin
            hex_digits_seen_next = hex_digits_seen + 2'd1;
            code_point_next      = cp;
          end
        end
      endcase
    end
  end

  // Results of this beat; the last one carries the run end flag.
  always_comb begin
    run = '0;
    if (beat.input_end) begin
      if (phase != jsu_pkg::PH_IDLE) begin
        run.res[0].kind = jsu_pkg::KIND_ERROR;
        run.count       = 2'd1;
      end
    end else begin
      case (phase)
        jsu_pkg::PH_IDLE: begin
          if (c != jsu_pkg::ChQuote && !is_space) begin
            run.res[0].kind = jsu_pkg::KIND_ERROR;
            run.count       = 2'd1;
          end
        end
        jsu_pkg::PH_STR: begin
          if (c == jsu_pkg::ChQuote) begin
            run.res[0].kind = jsu_pkg::KIND_CLOSE;
            run.count       = 2'd1;
          end else if (c < jsu_pkg::ChSpace) begin
            run.res[0].kind = jsu_pkg::KIND_ERROR;
            run.count       = 2'd1;
          end else if (c != jsu_pkg::ChBackslash) begin
            run.res[0].out_byte = c;
            run.count           = 2'd1;
          end
        end
        jsu_pkg::PH_ESC: begin
          if (c != jsu_pkg::ChLowU) begin
            if (esc_ok) begin
              run.res[0].out_byte = esc_byte;
            end else begin
              run.res[0].kind = jsu_pkg::KIND_ERROR;
            end
            run.count = 2'd1;
          end
        end
        default: begin
          if (!hex_ok) begin
            run.res[0].kind = jsu_pkg::KIND_ERROR;
            run.count       = 2'd1;
          end else if (hex_digits_seen == 2'd3) begin
            // UTF-8 encoding of the completed code point.
            if (cp[15:7] == 9'd0) begin
              run.res[0].out_byte = {1'b0, cp[6:0]};
              run.count           = 2'd1;
            end else if (cp[15:11] == 5'd0) begin
              run.res[0].out_byte = jsu_pkg::Utf8Lead2 | {3'd0, cp[10:6]};
              run.res[1].out_byte = jsu_pkg::Utf8Cont | {2'd0, cp[5:0]};
              run.count           = 2'd2;
            end else begin
              run.res[0].out_byte = jsu_pkg::Utf8Lead3 | {4'd0, cp[15:12]};
              run.res[1].out_byte = jsu_pkg::Utf8Cont | {2'd0, cp[11:6]};
              run.res[2].out_byte = jsu_pkg::Utf8Cont | {2'd0, cp[5:0]};
              run.count           = 2'd3;
            end
          end
        end
      endcase
    end
    run.res[0].last_of_run = (run.count == 2'd1);
    run.res[1].last_of_run = (run.count == 2'd2);
    run.res[2].last_of_run = (run.count == 2'd3);
  end

endmodule

>>> rtl/jsu_run_buf.sv
module jsu_run_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  jsu_pkg::run_t  run_in,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_stall,
  output jsu_pkg::out_t  out_data
);

  logic [1:0]                              count;
  jsu_pkg::out_t [jsu_pkg::MaxResults-1:0] res;
  logic                                    pop;

  // Move the head of the run into the output register when it is free.
  assign pop      = (count != 2'd0) && (!out_valid || !out_stall);
  assign can_load = (count == 2'd0) || (count == 2'd1 && pop);

  // Run register: loaded with a whole beat's results, drained one a cycle while the output register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= run_in.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= run_in.res;
    end else if (pop) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res[0];
    end
  end

endmodule

>>> tb/json_unescape_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the unescaper, predicts the result beats of every
// accepted input beat and compares each accepted result beat in order.
module json_unescape_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  input  logic          src_stall,
  input  jsu_pkg::in_t  src_data,
  input  logic          dst_valid,
  input  logic          dst_stall,
  input  jsu_pkg::out_t dst_data,
  output int            mismatches,
  output int            pending,
  output int            results_checked
);
  import jsu_pkg::*;

  // Shadow copy of the string decoder state.
  phase_t      str_phase;
  logic [1:0]  hex_count;
  logic [15:0] code_acc;

  // Decoded bytes, closes and errors still waiting to come out of the block.
  out_t decoded_q[$];

  function automatic out_t make_result(input logic [7:0] b, input kind_t k);
    out_t r;
    r.out_byte    = b;
    r.kind        = k;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  task automatic go_idle();
    str_phase = PH_IDLE;
    hex_count = 2'd0;
    code_acc  = 16'h0000;
  endtask

  // Advance the shadow decoder by one input beat and queue what it emits.
  task automatic decode_beat(input in_t beat);
    logic [7:0]  c;
    logic [7:0]  esc_byte;
    logic        esc_known;
    logic [3:0]  nib;
    logic        nib_ok;
    logic [15:0] cp;
    out_t        run [MaxResults];
    int          n;
    c = beat.in_byte;
    n = 0;
    if (beat.input_end) begin
      // Running out of input is only harmless between strings.
      if (str_phase != PH_IDLE) begin
        run[n] = make_result(8'h00, KIND_ERROR);
        n++;
      end
      go_idle();
    end else begin
      case (str_phase)
        PH_IDLE: begin
          // Whitespace is skipped; anything but a quote is an error.
          if (c == ChQuote) begin
            str_phase = PH_STR;
          end else if (!(c == ChSpace || (c >= 8'h09 && c <= 8'h0D))) begin
            run[n] = make_result(8'h00, KIND_ERROR);
            n++;
          end
        end
        PH_STR: begin
          if (c == ChQuote) begin
            run[n] = make_result(8'h00, KIND_CLOSE);
            n++;
            go_idle();
          end else if (c < ChSpace) begin
            run[n] = make_result(8'h00, KIND_ERROR);
            n++;
            go_idle();
          end else if (c == ChBackslash) begin
            str_phase = PH_ESC;
          end else begin
            run[n] = make_result(c, KIND_DATA);
            n++;
          end
        end
        PH_ESC: begin
          esc_known = 1'b1;
          case (c)
            ChQuote, ChBackslash, ChSlash: esc_byte = c;
            ChLowB: esc_byte = 8'h08;
            ChLowF: esc_byte = 8'h0C;
            ChLowN: esc_byte = 8'h0A;
            ChLowR: esc_byte = 8'h0D;
            ChLowT: esc_byte = 8'h09;
            default: begin
              esc_byte  = 8'h00;
              esc_known = 1'b0;
            end
          endcase
          if (c == ChLowU) begin
            str_phase = PH_HEX;
            hex_count = 2'd0;
            code_acc  = 16'h0000;
          end else if (esc_known) begin
            run[n] = make_result(esc_byte, KIND_DATA);
            n++;
            str_phase = PH_STR;
          end else begin
            run[n] = make_result(8'h00, KIND_ERROR);
            n++;
            go_idle();
          end
        end
        default: begin
          // Hex digit of a unicode escape; the low nibble of the ASCII code
          // gives the value directly for digits and is off by nine for letters.
          nib_ok = 1'b1;
          nib    = 4'h0;
          if (c >= "0" && c <= "9") begin
            nib = c[3:0];
          end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            nib = c[3:0] + 4'd9;
          end else begin
            nib_ok = 1'b0;
          end
          if (!nib_ok) begin
            run[n] = make_result(8'h00, KIND_ERROR);
            n++;
            go_idle();
          end else begin
            cp = {code_acc[11:0], nib};
            if (hex_count == 2'd3) begin
              // Fourth digit: encode the code point as UTF-8, surrogates alone.
              if (cp <= 16'h007F) begin
                run[n] = make_result(cp[7:0], KIND_DATA);
                n++;
              end else if (cp <= 16'h07FF) begin
                run[n] = make_result(Utf8Lead2 | {3'b000, cp[10:6]}, KIND_DATA);
                run[n + 1] = make_result(Utf8Cont | {2'b00, cp[5:0]}, KIND_DATA);
                n += 2;
              end else begin
                run[n] = make_result(Utf8Lead3 | {4'h0, cp[15:12]}, KIND_DATA);
                run[n + 1] = make_result(Utf8Cont | {2'b00, cp[11:6]}, KIND_DATA);
                run[n + 2] = make_result(Utf8Cont | {2'b00, cp[5:0]}, KIND_DATA);
                n += 3;
              end
              str_phase = PH_STR;
              hex_count = 2'd0;
              code_acc  = 16'h0000;
            end else begin
              code_acc = cp;
              hex_count++;
            end
          end
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) begin
        run[i].last_of_run = 1'b1;
      end
      decoded_q.insert(decoded_q.size(), run[i]);
    end
  endtask

  task automatic report_mismatch(input string why, input out_t want, input out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch %0d at %0t: %s", mismatches, $realtime, why);
      $display("  expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
               want.out_byte, want.kind, want.last_of_run,
               got.out_byte, got.kind, got.last_of_run);
    end
  endtask

  // Predict on every accepted input beat, compare on every accepted result beat.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      go_idle();
      decoded_q.delete();
      mismatches      = 0;
      results_checked = 0;
    end else begin
      if (src_valid && !src_stall) begin
        decode_beat(src_data);
      end
      if (dst_valid && !dst_stall) begin
        results_checked++;
        if (decoded_q.size() == 0) begin
          report_mismatch("result beat with none expected", '0, dst_data);
        end else begin
          want = decoded_q.pop_front();
          if (dst_data.out_byte !== want.out_byte || dst_data.kind !== want.kind ||
              dst_data.last_of_run !== want.last_of_run) begin
            report_mismatch("result beat differs", want, dst_data);
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

>>> tb/tb_json_string_unescaper_core.sv
`timescale 1ns / 100ps

module tb_json_string_unescaper_core;
  import jsu_pkg::*;

  localparam int RandomBeats = 165;
  localparam int QuietLimit  = 1000;
  localparam int TailCycles  = 8;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  in_t  src_data  = '0;
  logic dst_valid;
  logic dst_stall = 1'b0;
  out_t dst_data;

  int mismatches;
  int pending;
  int results_checked;

  int src_idle_pct   = 36;
  int dst_idle_pct   = 48;
  int beats_sent     = 0;
  int padding_beats  = 0;
  int directed_beats = 0;
  int strings_sent   = 0;
  int quiet_cycles   = 0;

  always #4 clk = ~clk;

  json_string_unescaper_core DUT (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

  json_unescape_checker decode_check (
    .clk             (clk),
    .rst             (rst),
    .src_valid       (src_valid),
    .src_stall       (src_stall),
    .src_data        (src_data),
    .dst_valid       (dst_valid),
    .dst_stall       (dst_stall),
    .dst_data        (dst_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // Receiver back-pressure.
  always @(posedge clk) begin
    dst_stall <= ($urandom_range(99) < dst_idle_pct);
  end

  // Give up when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Timeout: no beat accepted for %0d cycles", QuietLimit);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one input beat, with random gaps in front, and hold it until taken.
  task automatic send_beat(input logic [7:0] b, input logic is_end);
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid          <= 1'b1;
    src_data.in_byte   <= b;
    src_data.input_end <= is_end;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(b, 1'b0);
  endtask

  task automatic send_end();
    send_beat(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] escape_letter(input int k);
    case (k)
      0: return ChQuote;
      1: return ChBackslash;
      2: return ChSlash;
      3: return ChLowB;
      4: return ChLowF;
      5: return ChLowN;
      6: return ChLowR;
      default: return ChLowT;
    endcase
  endfunction

  // Hex digit in random letter case.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return "0" + nib;
    end
    return ($urandom_range(1) ? "A" : "a") + nib - 8'd10;
  endfunction

  task automatic send_unicode(input logic [15:0] cp);
    send_byte(ChBackslash);
    send_byte(ChLowU);
    for (int i = 3; i >= 0; i--) begin
      send_byte(hex_char(cp[i*4 +: 4]));
    end
  endtask

  // Cut a string short in one of the ways that must give an error.
  task automatic break_string();
    logic [7:0] b;
    logic       bad;
    int         how;
    how = $urandom_range(5);
    case (how)
      0: send_end();
      1: send_byte(8'($urandom_range(31)));
      2: begin
        do begin
          b   = 8'($urandom_range(255));
          bad = (b != ChLowU);
          for (int k = 0; k < 8; k++) begin
            if (b == escape_letter(k)) bad = 1'b0;
          end
        end while (!bad);
        send_byte(ChBackslash);
        send_byte(b);
      end
      3: begin
        send_byte(ChBackslash);
        send_end();
      end
      default: begin
        // Partial unicode escape, then a non-hex byte or the end of input.
        send_byte(ChBackslash);
        send_byte(ChLowU);
        repeat ($urandom_range(3)) send_byte(hex_char(4'($urandom_range(15))));
        if (how == 4) begin
          do b = 8'($urandom_range(255));
          while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                 (b >= "A" && b <= "F"));
          send_byte(b);
        end else begin
          send_end();
        end
      end
    endcase
  endtask

  // Quoted string with random plain bytes and escapes, now and then broken.
  task automatic send_random_string();
    logic [7:0]  b;
    logic [15:0] cp;
    int          pick;
    int          k;
    repeat ($urandom_range(2)) begin
      k = $urandom_range(6);
      send_byte((k == 6) ? ChSpace : 8'h09 + 8'(k));
      padding_beats++;
    end
    send_byte(ChQuote);
    repeat ($urandom_range(6)) begin
      pick = $urandom_range(99);
      if (pick < 7) begin
        break_string();
        return;
      end else if (pick < 45) begin
        do b = 8'($urandom_range(255, 32));
        while (b == ChQuote || b == ChBackslash);
        send_byte(b);
      end else if (pick < 75) begin
        send_byte(ChBackslash);
        send_byte(escape_letter($urandom_range(7)));
      end else begin
        case ($urandom_range(3))
          0: cp = 16'($urandom_range(16'h007F));
          1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
          2: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
          default: cp = 16'($urandom_range(16'hDFFF, 16'hD800));
        endcase
        send_unicode(cp);
      end
    end
    send_byte(ChQuote);
    strings_sent++;
  endtask

  initial begin
    int progress;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed beats: edges of the byte range, every escape, every error path.
    send_end();
    send_byte(ChSpace);
    send_byte(8'h0D);
    send_byte(8'h00);
    send_byte(ChQuote);
    send_byte(8'hFF);
    for (int k = 0; k < 8; k++) begin
      send_byte(ChBackslash);
      send_byte(escape_letter(k));
    end
    send_unicode(16'hFFFF);
    send_unicode(16'h07FF);
    send_byte(ChQuote);
    send_byte(ChQuote);
    send_byte(8'h1F);
    send_byte(ChQuote);
    send_byte(ChBackslash);
    send_byte("q");
    send_byte(ChQuote);
    send_byte(ChBackslash);
    send_byte(ChLowU);
    send_byte("g");
    send_byte(ChQuote);
    send_end();
    directed_beats = beats_sent;

    // Random part, in three idling regimes.
    progress = 0;
    while (progress < RandomBeats) begin
      if (progress < RandomBeats / 3) begin
        src_idle_pct = 36;
        dst_idle_pct = 48;
      end else if (progress < 2 * RandomBeats / 3) begin
        src_idle_pct = 48;
        dst_idle_pct = 36;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      if ($urandom_range(99) < 80) begin
        send_random_string();
      end else if ($urandom_range(7) == 0) begin
        send_end();
      end else begin
        send_byte(8'($urandom_range(255)));
      end
      progress = beats_sent - directed_beats - padding_beats;
    end
    src_valid <= 1'b0;

    // Drain, then keep watching for any stray result beat.
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);

    $display("Drove %0d input beats, %0d of them directed, with %0d complete random strings.",
             beats_sent, directed_beats, strings_sent);
    $display("Checked %0d result beats under three stall mixes; %0d mismatched.",
             results_checked, mismatches);
    if (pending != 0) begin
      $display("%0d expected result beats never arrived", pending);
    end
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
